@@ rtl/core/osas_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// osas_pkg
// Shared widths, codes and controller/datapath interface types for the
// ordered-subset angle scheduler.
// ----------------------------------------------------------------------------
package osas_pkg;

    // Angle store depth and field widths
    localparam int MAX_ANGLES  = 1024;
    localparam int ANG_W       = 10;   // angle index, subset number, position
    localparam int CNT_W       = 11;   // counts that must hold MAX_ANGLES
    localparam int CFG_W       = 11;   // configuration register width
    localparam int CFG_IDX_W   = 1;    // configuration register index width
    localparam int REV_BITS    = 16;   // bits of the reversed subset fraction
    localparam int PROD_W      = CNT_W + REV_BITS;
    localparam int CP_W        = CNT_W + ANG_W;
    localparam int DIV_NUM_W   = CP_W; // widest dividend is the base angle
    localparam int DIV_CNT_W   = 5;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] ANGLE_COUNT_RST   = CFG_W'(256);
    localparam logic [CFG_W-1:0] SUBSET_LENGTH_RST = CFG_W'(16);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_COUNT   = 1'b0,
        CFG_SUBSET_LENGTH = 1'b1
    } t_cfg_reg;

    // Operand selection of the shared divider
    typedef enum logic [1:0] {
        DIV_N = 2'd0,   // issued count / subset length
        DIV_A = 2'd1,   // angle count / subset length
        DIV_B = 2'd2    // base angle mod angle count
    } t_div_sel;

    // Controller states
    typedef enum logic [3:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_RST_CLR,
        ST_CHECK,
        ST_DIV_S,
        ST_DIV_Q,
        ST_MUL,
        ST_BASE,
        ST_DIV_B,
        ST_PROBE_RD,
        ST_PROBE_CK,
        ST_EMIT,
        ST_EMIT_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic     in_ready;
        logic     take;
        logic     clr_step;
        logic     div_start;
        t_div_sel div_sel;
        logic     save_s;
        logic     save_q;
        logic     mul;
        logic     save_pos;
        logic     probe_rd;
        logic     probe_adv;
        logic     mark;
        logic     emit;
        logic     emit_done;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic restart_in;
        logic clr_last;
        logic is_done;
        logic div_done;
        logic div_busy;
        logic rd_used;
        logic tries_full;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

@@ rtl/core/osas_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// osas_divider
// Restoring divider, one quotient bit per cycle. Operands are captured at
// start; quotient and remainder hold until the next start.
// ----------------------------------------------------------------------------
module osas_divider
    import osas_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DIV_NUM_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0]     i_divisor,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [DIV_NUM_W-1:0]      o_quotient,
    output logic [CNT_W-1:0]          o_remainder
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_NUM_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0]     r_rem, n_rem;
    logic [CNT_W-1:0]     r_dvs, n_dvs;
    logic [CNT_W:0]       rem_sh;
    logic [CNT_W:0]       rem_sub;
    logic                 fits;

    // Shift in the next dividend bit and trial-subtract
    assign rem_sh  = {r_rem, r_quo[DIV_NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign fits    = (rem_sh >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_NUM_W - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[DIV_NUM_W-2:0], fits};
            n_rem = fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Operand and result registers
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

@@ rtl/core/osas_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// osas_datapath
// Configuration registers, schedule arithmetic, used-angle map and output
// register of the ordered-subset angle scheduler.
// ----------------------------------------------------------------------------
module osas_datapath
    import osas_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    // input word payload: [0] restart, [7:1] zero
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // output channel
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [9:0] angle_index, [19:10] subset_number, [29:20] subset_position, [31:30] zero
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                        o_m_axis_tlast,
    // [0] done_res
    output logic                        o_m_axis_tuser,
    // controller link
    input  wire t_cmd                   i_cmd,
    output t_stat                       o_stat
);

    // Bit-reverse the subset number taken to REV_BITS bits
    function automatic logic [REV_BITS-1:0] rev_bits(input logic [ANG_W-1:0] v);
        logic [REV_BITS-1:0] w;
        logic [REV_BITS-1:0] r;
        w = REV_BITS'(v);
        for (int k = 0; k < REV_BITS; k++) begin
            r[REV_BITS-1-k] = w[k];
        end
        return r;
    endfunction

    logic [CFG_W-1:0]     r_angle_count;
    logic [CFG_W-1:0]     r_subset_length;
    logic [CNT_W-1:0]     a_eff;
    logic [CNT_W-1:0]     l_eff;

    logic [CNT_W-1:0]     r_issued;
    logic [ANG_W-1:0]     r_clr_addr;
    logic [ANG_W-1:0]     r_s;
    logic [ANG_W-1:0]     r_p;
    logic [CNT_W-1:0]     r_q;
    logic [CNT_W-1:0]     r_c;
    logic [CNT_W-1:0]     r_off;
    logic [CP_W-1:0]      r_cp;
    logic [ANG_W-1:0]     r_pos;
    logic [CNT_W-1:0]     r_tries;
    logic                 r_rd_used;
    logic                 r_used_mem [MAX_ANGLES];

    logic                 r_out_valid;
    logic [ANG_W-1:0]     r_out_angle;
    logic [ANG_W-1:0]     r_out_s;
    logic [ANG_W-1:0]     r_out_p;
    logic                 r_out_last;
    logic                 r_out_done;

    logic [PROD_W-1:0]    off_prod;
    logic [CP_W-1:0]      base;
    logic [CNT_W-1:0]     pos_inc;
    logic                 last_flag;

    logic                 div_busy;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;
    logic [CNT_W-1:0]     div_rem;
    logic [DIV_NUM_W-1:0] div_num;
    logic [CNT_W-1:0]     div_dvs;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_count   <= ANGLE_COUNT_RST;
            r_subset_length <= SUBSET_LENGTH_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_ANGLE_COUNT:   r_angle_count   <= i_cfg_data;
                CFG_SUBSET_LENGTH: r_subset_length <= i_cfg_data;
            endcase
        end
    end

    // Clamp angle count to 1..MAX_ANGLES and subset length to at least 1
    always_comb begin
        if (r_angle_count == '0) begin
            a_eff = CNT_W'(1);
        end else if (r_angle_count > CFG_W'(MAX_ANGLES)) begin
            a_eff = CNT_W'(MAX_ANGLES);
        end else begin
            a_eff = r_angle_count;
        end
        l_eff = (r_subset_length == '0) ? CNT_W'(1) : r_subset_length;
    end

    // Divider operand selection
    always_comb begin
        case (i_cmd.div_sel)
            DIV_N: begin
                div_num = DIV_NUM_W'(r_issued);
                div_dvs = l_eff;
            end
            DIV_A: begin
                div_num = DIV_NUM_W'(a_eff);
                div_dvs = l_eff;
            end
            DIV_B: begin
                div_num = base;
                div_dvs = a_eff;
            end
            default: begin
                div_num = '0;
                div_dvs = CNT_W'(1);
            end
        endcase
    end

    osas_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_num),
        .i_divisor   (div_dvs),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Offset product and base angle
    assign off_prod = PROD_W'(r_q) * PROD_W'(rev_bits(r_s));
    assign base     = CP_W'(r_off) + r_cp;
    assign pos_inc  = CNT_W'(r_pos) + 1'b1;

    // Control counters: issued count, clear address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issued   <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.take && i_s_axis_tdata[0]) begin
                r_issued <= '0;
            end else if (i_cmd.mark) begin
                r_issued <= r_issued + 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Schedule arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_s) begin
            r_s <= div_quo[ANG_W-1:0];
            r_p <= div_rem[ANG_W-1:0];
        end
        if (i_cmd.save_q) begin
            r_q <= div_quo[CNT_W-1:0];
            r_c <= div_quo[CNT_W-1:0] + CNT_W'(div_rem != '0);
        end
        if (i_cmd.mul) begin
            r_off <= off_prod[PROD_W-1:REV_BITS];
            r_cp  <= CP_W'(r_c) * CP_W'(r_p);
        end
    end

    // Probe position and try count
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_pos) begin
            r_pos   <= div_rem[ANG_W-1:0];
            r_tries <= '0;
        end else if (i_cmd.probe_adv) begin
            r_pos   <= (pos_inc >= a_eff) ? '0 : pos_inc[ANG_W-1:0];
            r_tries <= r_tries + 1'b1;
        end
    end

    // Used-angle map: clear sweep or mark on write, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_used_mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.mark) begin
            r_used_mem[r_pos] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_rd) begin
            r_rd_used <= r_used_mem[r_pos];
        end
    end

    assign last_flag = ({1'b0, r_p} == (l_eff - 1'b1)) || (r_issued == (a_eff - 1'b1));

    // Output register: load a word, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_angle <= r_pos;
            r_out_s     <= r_s;
            r_out_p     <= r_p;
            r_out_last  <= last_flag;
            r_out_done  <= 1'b0;
        end else if (i_cmd.emit_done) begin
            r_out_angle <= '0;
            r_out_s     <= '0;
            r_out_p     <= '0;
            r_out_last  <= 1'b0;
            r_out_done  <= 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - 3 * ANG_W)'(0), r_out_p, r_out_s, r_out_angle};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_done;

    // Status to the controller
    always_comb begin
        o_stat            = '0;
        o_stat.restart_in = i_s_axis_tdata[0];
        o_stat.clr_last   = (r_clr_addr == '1);
        o_stat.is_done    = (r_issued >= a_eff);
        o_stat.div_done   = div_done;
        o_stat.div_busy   = div_busy;
        o_stat.rd_used    = r_rd_used;
        o_stat.tries_full = (r_tries == a_eff);
        o_stat.out_free   = !r_out_valid || i_m_axis_tready;
    end

endmodule
`default_nettype wire

@@ rtl/core/osas_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// osas_ctrl
// Sequencer of the ordered-subset angle scheduler: map clearing, the three
// divisions, the offset multiply, the free-angle probe and the output load.
// ----------------------------------------------------------------------------
module osas_ctrl
    import osas_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_axis_tvalid,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output t_state     o_state
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT_CLR: begin
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = i_stat.restart_in ? ST_RST_CLR : ST_CHECK;
                end
            end
            ST_RST_CLR: begin
                if (i_stat.clr_last) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_stat.is_done ? ST_EMIT_DONE : ST_DIV_S;
            end
            ST_DIV_S: begin
                if (i_stat.div_done) n_state = ST_DIV_Q;
            end
            ST_DIV_Q: begin
                if (i_stat.div_done) n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_BASE;
            end
            ST_BASE: begin
                n_state = ST_DIV_B;
            end
            ST_DIV_B: begin
                if (i_stat.div_done) n_state = ST_PROBE_RD;
            end
            ST_PROBE_RD: begin
                n_state = ST_PROBE_CK;
            end
            ST_PROBE_CK: begin
                if (i_stat.rd_used && !i_stat.tries_full) begin
                    n_state = ST_PROBE_RD;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            ST_EMIT_DONE: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT_CLR;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DIV_N;
        unique case (r_state)
            ST_INIT_CLR: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.take     = i_s_axis_tvalid;
            end
            ST_RST_CLR: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_CHECK: begin
                o_cmd.div_start = !i_stat.is_done;
                o_cmd.div_sel   = DIV_N;
            end
            ST_DIV_S: begin
                o_cmd.save_s    = i_stat.div_done;
                o_cmd.div_start = i_stat.div_done;
                o_cmd.div_sel   = DIV_A;
            end
            ST_DIV_Q: begin
                o_cmd.save_q = i_stat.div_done;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_BASE: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_B;
            end
            ST_DIV_B: begin
                o_cmd.save_pos = i_stat.div_done;
            end
            ST_PROBE_RD: begin
                o_cmd.probe_rd = 1'b1;
            end
            ST_PROBE_CK: begin
                o_cmd.probe_adv = i_stat.rd_used && !i_stat.tries_full;
            end
            ST_EMIT: begin
                o_cmd.mark = i_stat.out_free;
                o_cmd.emit = i_stat.out_free;
            end
            ST_EMIT_DONE: begin
                o_cmd.emit_done = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_state = r_state;

endmodule
`default_nettype wire

@@ rtl/core/ordered_subset_angle_scheduler_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_subset_angle_scheduler_top
// Hands out projection-angle indices in ordered-subset order, one per word.
// The wait from request word to result word, and between request words taken,
//   is set by the three bit-serial divisions and by the map reads of the probe;
//   no request word is taken until the last result word is loaded.
// A done word skips the divisions and the probe.
// Restart adds a clearing sweep over all 1024 entries of the used-angle map.
// After reset the whole map is swept with the input not ready;
//   configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module ordered_subset_angle_scheduler_top
    import osas_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write: index 0 angle_count, 1 subset_length
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    // request channel
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [0] restart, [7:1] zero
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // result channel
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [9:0] angle_index, [19:10] subset_number, [29:20] subset_position, [31:30] zero
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // last_in_subset
    output logic                        o_m_axis_tlast,
    // [0] done_res
    output logic                        o_m_axis_tuser
);

    t_cmd   cmd;
    t_stat  stat;
    t_state state;

    osas_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_stat          (stat),
        .o_cmd           (cmd),
        .o_state         (state)
    );

    osas_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cmd           (cmd),
        .o_stat          (stat)
    );

    assign o_s_axis_tready = cmd.in_ready;

    // No request is taken while the map is being swept
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_step |-> !o_s_axis_tready)
        else $error("request ready during map clearing");

    // An angle is marked only when the probe found it free or ran out
    a_mark_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mark |-> (!stat.rd_used || stat.tries_full))
        else $error("marking an angle already in use");

    // The divider is started only when idle
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider restarted while busy");

    // A done word carries no angle, subset or position
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0 && !o_m_axis_tlast))
        else $error("done word with nonzero payload");

    // Results are loaded only from an emitting state
    a_emit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit || cmd.emit_done) |-> (state == ST_EMIT || state == ST_EMIT_DONE))
        else $error("result loaded outside an emitting state");

endmodule
`default_nettype wire

@@ tb/ordered_subset_angle_scheduler_top_test.sv @@
// ----------------------------------------------------------------------------
// ordered_subset_angle_scheduler_top_test
// Drives schedule requests into the angle scheduler and checks every result
// word against a local model of the ordered-subset angle order. The run
// covers register extremes, short and full schedules, restarts, register
// changes in the middle of a schedule, and back-pressure on both sides.
// ----------------------------------------------------------------------------
module ordered_subset_angle_scheduler_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import osas_pkg::*;

    localparam int TARGET_REQUESTS = 1450;
    localparam int MAX_REPORTS     = 40;

    // One result word, split into its fields
    typedef struct packed {
        logic [ANG_W-1:0] angle;
        logic [ANG_W-1:0] subset;
        logic [ANG_W-1:0] position;
        logic             last_in_subset;
        logic             done;
    } t_angle_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;
    logic                   o_m_axis_tuser;

    // Scheduler state as the model sees it
    logic [CFG_W-1:0] sched_angle_count = ANGLE_COUNT_RST;
    logic [CFG_W-1:0] sched_subset_length = SUBSET_LENGTH_RST;
    bit               angle_taken [MAX_ANGLES];
    int unsigned      angles_issued = 0;

    t_angle_word angle_words_due [$];
    int          requests_sent = 0;
    int          fail_count = 0;

    // Idling controls
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int rx_gap_left = 0;
    int result_hold_cycles = 0;

    ordered_subset_angle_scheduler_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Work out the next angle word; updates the used map and issue count
    function automatic t_angle_word issue_next_angle(input logic restart);
        int unsigned        a, l, n, s, p, q, c, pos, tries;
        bit [REV_BITS-1:0]  s_low, s_rev;
        logic [63:0]        base;
        t_angle_word        w;
        a = sched_angle_count;
        l = sched_subset_length;
        if (a == 0)
            a = 1;
        if (a > MAX_ANGLES)
            a = MAX_ANGLES;
        if (l == 0)
            l = 1;
        if (restart) begin
            foreach (angle_taken[i])
                angle_taken[i] = 1'b0;
            angles_issued = 0;
        end
        w = '0;
        n = angles_issued;
        // all angles handed out: flag done and leave state alone
        if (n >= a) begin
            w.done = 1'b1;
            return w;
        end
        s = n / l;
        p = n % l;
        q = a / l;
        c = (a + l - 1) / l;
        // offset is q times the bit-reversed fraction of the subset number
        s_low = s[REV_BITS-1:0];
        for (int k = 0; k < REV_BITS; k++)
            s_rev[REV_BITS-1-k] = s_low[k];
        base = (64'(q) * 64'(s_rev)) >> REV_BITS;
        base = base + 64'(c) * 64'(p);
        pos = int'(base % 64'(a));
        // probe forward, wrapping, to the first free angle
        for (tries = 0; tries < a && angle_taken[pos]; tries++) begin
            pos++;
            if (pos >= a)
                pos = 0;
        end
        angle_taken[pos] = 1'b1;
        angles_issued = n + 1;
        w.angle          = pos[ANG_W-1:0];
        w.subset         = s[ANG_W-1:0];
        w.position       = p[ANG_W-1:0];
        w.last_in_subset = (p == l - 1) || (n == a - 1);
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (fail_count < MAX_REPORTS)
            $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Check each accepted result word against the oldest expected one
    always @(posedge i_clk) begin : result_check
        t_angle_word got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.angle          = o_m_axis_tdata[ANG_W-1:0];
            got.subset         = o_m_axis_tdata[2*ANG_W-1:ANG_W];
            got.position       = o_m_axis_tdata[3*ANG_W-1:2*ANG_W];
            got.last_in_subset = o_m_axis_tlast;
            got.done           = o_m_axis_tuser;
            if (angle_words_due.size() == 0) begin
                report_mismatch("unexpected result word, angle_index", got.angle, 0);
            end else begin
                want = angle_words_due.pop_front();
                if (got.angle !== want.angle)
                    report_mismatch("angle_index", got.angle, want.angle);
                if (got.subset !== want.subset)
                    report_mismatch("subset_number", got.subset, want.subset);
                if (got.position !== want.position)
                    report_mismatch("subset_position", got.position, want.position);
                if (got.last_in_subset !== want.last_in_subset)
                    report_mismatch("last_in_subset", got.last_in_subset,
                                    want.last_in_subset);
                if (got.done !== want.done)
                    report_mismatch("done_res", got.done, want.done);
            end
        end
    end

    // Result side ready: long holds first, then random gaps
    always @(negedge i_clk) begin : result_ready_gen
        if (result_hold_cycles > 0) begin
            i_m_axis_tready <= 1'b0;
            result_hold_cycles--;
        end else if (rx_gap_left > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_gap_left--;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (!rx_steady)
                rx_gap_left = pick_gap();
        end
    end

    task automatic write_register(input t_cfg_reg idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_ANGLE_COUNT)
            sched_angle_count = value;
        else
            sched_subset_length = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_schedule(input logic [CFG_W-1:0] angles,
                                input logic [CFG_W-1:0] length);
        write_register(CFG_ANGLE_COUNT, angles);
        write_register(CFG_SUBSET_LENGTH, length);
    endtask

    // Offer one request word; valid stays high until the next call decides
    task automatic send_request(input logic restart);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, restart};
        do @(posedge i_clk); while (!o_s_axis_tready);
        angle_words_due.push_back(issue_next_angle(restart));
        requests_sent++;
    endtask

    // Drop valid and wait for every expected word to come back
    task automatic finish_phase();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (angle_words_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_schedule(input int count, input logic first_restart);
        for (int i = 0; i < count; i++)
            send_request(i == 0 ? first_restart : 1'b0);
        finish_phase();
    endtask

    // Default registers straight out of reset, map already clear
    task automatic test_reset_defaults();
        send_schedule(4, 1'b0);
        send_schedule(1, 1'b1);
    endtask

    // One-angle schedules, including zero counts and lengths
    task automatic test_tiny_schedules();
        set_schedule(CFG_W'(1), CFG_W'(1));
        send_schedule(3, 1'b1);
        set_schedule(CFG_W'(0), CFG_W'(0));
        send_schedule(2, 1'b1);
    endtask

    // Saturated count, length above count, largest legal values
    task automatic test_register_extremes();
        set_schedule(CFG_W'(2047), CFG_W'(2047));
        send_schedule(3, 1'b1);
        set_schedule(CFG_W'(1024), CFG_W'(1));
        send_schedule(3, 1'b1);
        set_schedule(CFG_W'(1024), CFG_W'(1024));
        send_schedule(2, 1'b1);
        set_schedule(CFG_W'(5), CFG_W'(9));
        send_schedule(6, 1'b1);
    endtask

    // Hold the result side so the block fills up and stalls the sender
    task automatic test_backpressure();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        set_schedule(CFG_W'(64), CFG_W'(8));
        result_hold_cycles = 1500;
        for (int i = 0; i < 12; i++)
            send_request(i == 0);
        finish_phase();
        send_schedule(4, 1'b0);
        send_schedule(4, 1'b0);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Random schedules: mostly clean runs, some noise and broken sequences
    task automatic test_random_schedules();
        int          r, count, a_eff;
        logic [CFG_W-1:0] angles, length;
        logic        restart;
        logic [CFG_W-1:0] extremes [6];
        extremes = '{CFG_W'(0), CFG_W'(1), CFG_W'(1023), CFG_W'(1024),
                     CFG_W'(1025), CFG_W'(2047)};
        while (requests_sent < TARGET_REQUESTS) begin
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 70) begin
                angles = CFG_W'($urandom_range(1, 40));
                length = CFG_W'($urandom_range(1, angles + 3));
            end else if (r < 80) begin
                angles = CFG_W'($urandom_range(41, 200));
                length = CFG_W'($urandom_range(1, 64));
            end else if (r < 90) begin
                angles = CFG_W'($urandom_range(0, 2047));
                length = CFG_W'($urandom_range(0, 2047));
            end else begin
                angles = extremes[$urandom_range(0, 5)];
                length = extremes[$urandom_range(0, 5)];
            end
            set_schedule(angles, length);
            a_eff = (angles == 0) ? 1 : ((angles > MAX_ANGLES) ? MAX_ANGLES : angles);
            if (a_eff <= 40 || (a_eff <= 200 && $urandom_range(0, 3) == 0))
                count = a_eff + $urandom_range(0, 3);
            else
                count = $urandom_range(4, 30);
            // keep the schedule going under new registers now and then
            restart = ($urandom_range(0, 99) < 85);
            for (int i = 0; i < count; i++) begin
                if (i == 0)
                    send_request(restart);
                else
                    send_request($urandom_range(0, 99) < 3);
                if ($urandom_range(0, 99) < 4)
                    finish_phase();
            end
            finish_phase();
        end
    endtask

    initial begin : main_flow
        foreach (angle_taken[i])
            angle_taken[i] = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_tiny_schedules();
        test_register_extremes();
        test_backpressure();
        test_random_schedules();
        finish_phase();
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Give up well past the slowest legal run
    initial begin : run_limit
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
